// File: rtl/lsf_pkg.sv
// Shared types, constants and the sequencer program of the low shelf filter.
`default_nettype none

package lsf_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 40;

    // Coefficient values after reset, Q24.40.
    localparam logic [63:0] RST_INV_TAN    = 64'd335984700000000;
    localparam logic [63:0] RST_NORM       = 64'd11736400;
    localparam logic [63:0] RST_INV_TAN_SQ = 64'd102668100000000000;
    localparam logic [63:0] RST_POLE       = 64'd1092338000000;
    localparam logic [63:0] RST_FO_NORM    = 64'd3586410000;
    localparam logic [63:0] RST_BQ_FB      = 64'd102334200000000000;
    localparam logic [62:0] RST_SHELF      = 63'd1099511627776;

    // Register map, one 64-bit register every eight bytes.
    typedef enum logic [2:0] {
        REG_INV_TAN    = 3'd0,
        REG_NORM       = 3'd1,
        REG_INV_TAN_SQ = 3'd2,
        REG_POLE       = 3'd3,
        REG_FO_NORM    = 3'd4,
        REG_BQ_FB      = 3'd5,
        REG_SHELF      = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [63:0] inv_tan;
        logic [63:0] norm;
        logic [63:0] inv_tan_sq;
        logic [63:0] pole;
        logic [63:0] fo_norm;
        logic [63:0] bq_fb;
        logic [62:0] shelf;
    } coef_t;

    typedef enum logic [1:0] {
        K_ALU,
        K_MUL,
        K_OUT
    } kind_t;

    typedef enum logic {
        OP_ADD,
        OP_SUB
    } alu_op_t;

    // Operand sources of the shared datapath.
    typedef enum logic [4:0] {
        SRC_ZERO, SRC_ONE,
        SRC_A, SRC_N, SRC_S, SRC_P, SRC_G, SRC_B, SRC_K,
        SRC_X, SRC_PREV,
        SRC_HP1, SRC_HH0, SRC_HH1, SRC_LP1, SRC_LH0, SRC_LH1,
        SRC_PROD,
        SRC_T0, SRC_T1, SRC_HP1N, SRC_HB, SRC_LP1N, SRC_LB, SRC_C9, SRC_C10
    } src_t;

    // Scratch registers that an ALU step may write.
    typedef enum logic [2:0] {
        DST_T0, DST_T1, DST_HP1N, DST_HB, DST_LP1N, DST_LB, DST_C9, DST_C10
    } dst_t;

    typedef struct packed {
        kind_t   kind;
        src_t    a;
        src_t    b;
        alu_op_t op;
        dst_t    dst;
    } instr_t;

    typedef struct packed {
        logic    capture;
        logic    clear;
        logic    mul_start;
        logic    alu_we;
        logic    out_load;
        alu_op_t op;
        src_t    src_a;
        src_t    src_b;
        dst_t    dst;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
    } stat_t;

    localparam int PROG_LEN = 42;
    localparam int PC_W     = $clog2(PROG_LEN);
    typedef logic [PC_W-1:0] pc_t;

    // One sample's worth of work. Products land in SRC_PROD; ALU steps
    // saturate to 64 bits.
    function automatic instr_t prog_rom(input pc_t pc);
        instr_t r;
        case (pc)
            // Biquad feedback constants 2(1-S) and -2S.
            0:  r = '{K_ALU, SRC_ONE,  SRC_S,    OP_SUB, DST_T0};
            1:  r = '{K_ALU, SRC_T0,   SRC_T0,   OP_ADD, DST_C9};
            2:  r = '{K_ALU, SRC_S,    SRC_S,    OP_ADD, DST_T0};
            3:  r = '{K_ALU, SRC_ZERO, SRC_T0,   OP_SUB, DST_C10};
            // Highpass first-order section.
            4:  r = '{K_MUL, SRC_A,    SRC_X,    OP_ADD, DST_T0};
            5:  r = '{K_ALU, SRC_PROD, SRC_ZERO, OP_ADD, DST_T0};
            6:  r = '{K_MUL, SRC_A,    SRC_PREV, OP_ADD, DST_T0};
            7:  r = '{K_ALU, SRC_T0,   SRC_PROD, OP_SUB, DST_T0};
            8:  r = '{K_MUL, SRC_G,    SRC_T0,   OP_ADD, DST_T0};
            9:  r = '{K_ALU, SRC_PROD, SRC_ZERO, OP_ADD, DST_T1};
            10: r = '{K_MUL, SRC_P,    SRC_HP1,  OP_ADD, DST_T0};
            11: r = '{K_ALU, SRC_PROD, SRC_T1,   OP_ADD, DST_HP1N};
            // Highpass biquad.
            12: r = '{K_MUL, SRC_B,    SRC_HH1,  OP_ADD, DST_T0};
            13: r = '{K_ALU, SRC_PROD, SRC_ZERO, OP_ADD, DST_T0};
            14: r = '{K_MUL, SRC_C9,   SRC_HH0,  OP_ADD, DST_T0};
            15: r = '{K_ALU, SRC_T0,   SRC_PROD, OP_ADD, DST_T0};
            16: r = '{K_MUL, SRC_N,    SRC_T0,   OP_ADD, DST_T0};
            17: r = '{K_ALU, SRC_HP1N, SRC_PROD, OP_SUB, DST_HB};
            // Lowpass first-order section.
            18: r = '{K_MUL, SRC_P,    SRC_LP1,  OP_ADD, DST_T0};
            19: r = '{K_ALU, SRC_PROD, SRC_ZERO, OP_ADD, DST_T0};
            20: r = '{K_ALU, SRC_PREV, SRC_X,    OP_ADD, DST_T1};
            21: r = '{K_MUL, SRC_G,    SRC_T1,   OP_ADD, DST_T0};
            22: r = '{K_ALU, SRC_T0,   SRC_PROD, OP_ADD, DST_LP1N};
            // Lowpass biquad.
            23: r = '{K_MUL, SRC_B,    SRC_LH1,  OP_ADD, DST_T0};
            24: r = '{K_ALU, SRC_PROD, SRC_ZERO, OP_ADD, DST_T0};
            25: r = '{K_MUL, SRC_C9,   SRC_LH0,  OP_ADD, DST_T0};
            26: r = '{K_ALU, SRC_T0,   SRC_PROD, OP_ADD, DST_T0};
            27: r = '{K_MUL, SRC_N,    SRC_T0,   OP_ADD, DST_T0};
            28: r = '{K_ALU, SRC_LP1N, SRC_PROD, OP_SUB, DST_LB};
            // Highpass numerator sum.
            29: r = '{K_MUL, SRC_S,    SRC_HB,   OP_ADD, DST_T0};
            30: r = '{K_ALU, SRC_PROD, SRC_ZERO, OP_ADD, DST_T0};
            31: r = '{K_MUL, SRC_C10,  SRC_HH0,  OP_ADD, DST_T0};
            32: r = '{K_ALU, SRC_T0,   SRC_PROD, OP_ADD, DST_T0};
            33: r = '{K_MUL, SRC_S,    SRC_HH1,  OP_ADD, DST_T0};
            34: r = '{K_ALU, SRC_T0,   SRC_PROD, OP_ADD, DST_T0};
            // Lowpass numerator sum, shelf gain and final normalization.
            35: r = '{K_ALU, SRC_LH0,  SRC_LH0,  OP_ADD, DST_T1};
            36: r = '{K_ALU, SRC_LB,   SRC_T1,   OP_ADD, DST_T1};
            37: r = '{K_ALU, SRC_LH1,  SRC_T1,   OP_ADD, DST_T1};
            38: r = '{K_MUL, SRC_K,    SRC_T1,   OP_ADD, DST_T0};
            39: r = '{K_ALU, SRC_T0,   SRC_PROD, OP_ADD, DST_T0};
            40: r = '{K_MUL, SRC_N,    SRC_T0,   OP_ADD, DST_T0};
            41: r = '{K_OUT, SRC_ZERO, SRC_ZERO, OP_ADD, DST_T0};
            default: r = '{K_OUT, SRC_ZERO, SRC_ZERO, OP_ADD, DST_T0};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/low_shelf_iir_filter.sv
// Top level of the third-order low shelf filter: register file, controller, datapath.
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: sample_in; s_tuser: clear_state
// m_        out  m_tvalid/m_tready  m_tdata: sample_out
// APB       in   psel/penable       seven 64-bit coefficients at 8*index
//
// Each filtering word runs from acceptance to the result register through
// 17 products on the one shared 32x32 multiplier (four partial products, an
// accumulate drain and a round/saturate step each), 24 saturating add steps,
// and one step each to accept and to write back. A word with clear_state set
// is taken and gives no result. Reset is synchronous and active low; it zeroes
// the filter state and loads the default coefficients. The input is ready
// again once the result is in the output register, so a stalled output only
// holds the next word back when that word is ready to deliver its own result.
module low_shelf_iir_filter import lsf_pkg::*; #(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input stream.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata, lowest bit up: sample_in, zero padding to whole bytes.
    input  wire logic [8*((SAMPLE_BITS+7)/8)-1:0]   s_tdata,
    // s_tuser: clear_state.
    input  wire logic                               s_tuser,
    // Output stream.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata, lowest bit up: sample_out, zero padding to whole bytes.
    output logic [8*((SAMPLE_BITS+7)/8)-1:0]        m_tdata,
    // Configuration.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [5:0]                         paddr,
    input  wire logic [63:0]                        pwdata,
    output logic [63:0]                             prdata,
    output logic                                    pready
);

    localparam int DATA_W = 8 * ((SAMPLE_BITS + 7) / 8);

    coef_t    coef_reg;
    reg_idx_t reg_idx;
    logic     cfg_we;
    cmd_t     cmd;
    stat_t    stat;
    logic [SAMPLE_BITS-1:0] sample_out;

    // Registers sit on eight-byte boundaries; the low address bits are ignored.
    assign reg_idx = reg_idx_t'(paddr[5:3]);
    assign cfg_we  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Software is to write only while no word is in flight; the block leaves that
    // to software, and the datapath reads the registers directly, with no shadow copy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.inv_tan    <= RST_INV_TAN;
            coef_reg.norm       <= RST_NORM;
            coef_reg.inv_tan_sq <= RST_INV_TAN_SQ;
            coef_reg.pole       <= RST_POLE;
            coef_reg.fo_norm    <= RST_FO_NORM;
            coef_reg.bq_fb      <= RST_BQ_FB;
            coef_reg.shelf      <= RST_SHELF;
        end else if (cfg_we) begin
            case (reg_idx)
                REG_INV_TAN:    coef_reg.inv_tan    <= pwdata;
                REG_NORM:       coef_reg.norm       <= pwdata;
                REG_INV_TAN_SQ: coef_reg.inv_tan_sq <= pwdata;
                REG_POLE:       coef_reg.pole       <= pwdata;
                REG_FO_NORM:    coef_reg.fo_norm    <= pwdata;
                REG_BQ_FB:      coef_reg.bq_fb      <= pwdata;
                // The shelf gain is unsigned; its top data bit is dropped.
                REG_SHELF:      coef_reg.shelf      <= pwdata[62:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_INV_TAN:    prdata = coef_reg.inv_tan;
            REG_NORM:       prdata = coef_reg.norm;
            REG_INV_TAN_SQ: prdata = coef_reg.inv_tan_sq;
            REG_POLE:       prdata = coef_reg.pole;
            REG_FO_NORM:    prdata = coef_reg.fo_norm;
            REG_BQ_FB:      prdata = coef_reg.bq_fb;
            REG_SHELF:      prdata = {1'b0, coef_reg.shelf};
            default:        prdata = 64'd0;
        endcase
    end

    // The controller walks the fixed program; the datapath does the math.
    lsf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_clear (s_tuser),
        .s_ready (s_tready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lsf_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .coef       (coef_reg),
        .sample_in  (s_tdata[SAMPLE_BITS-1:0]),
        .stat       (stat),
        .sample_out (sample_out)
    );

    // The result sits in the low bits; padding bits read as zero.
    assign m_tdata = DATA_W'(sample_out);

endmodule

`default_nettype wire

// File: rtl/lsf_mul.sv
// Sequential 64x64 signed fixed-point multiplier with rounding and saturation.
`default_nettype none

module lsf_mul import lsf_pkg::*; #(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] op_a,
    input  wire logic [63:0] op_b,
    output logic             done,
    output logic [63:0]      product
);

    localparam int          TOP_LO = COEF_FRAC_BITS + 63;
    localparam logic [127:0] HALF  = 128'd1 << (COEF_FRAC_BITS - 1);

    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [2:0]   step_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [63:0]  product_reg;

    logic [31:0]  a_half, b_half;
    logic [127:0] pp_ext;
    logic [63:0]  sat_val;
    logic         fits;

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // Partial order: a0*b0, a1*b0, a0*b1, a1*b1.
    assign a_half = step_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
    assign b_half = step_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
    assign pp_ext = {64'd0, pp_reg} << {sh_reg, 5'd0};

    assign fits    = (&acc_reg[127:TOP_LO]) || !(|acc_reg[127:TOP_LO]);
    assign sat_val = fits ? acc_reg[TOP_LO:COEF_FRAC_BITS]
                          : (acc_reg[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd5) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ma_reg  <= mag(op_a);
            mb_reg  <= mag(op_b);
            neg_reg <= op_a[63] ^ op_b[63];
            acc_reg <= HALF;
        end else if (busy_reg) begin
            if (step_reg <= 3'd3) begin
                pp_reg <= a_half * b_half;
                sh_reg <= 2'(step_reg[0]) + 2'(step_reg[1]);
            end
            if (step_reg >= 3'd1 && step_reg <= 3'd4) begin
                acc_reg <= neg_reg ? (acc_reg - pp_ext) : (acc_reg + pp_ext);
            end
            if (step_reg == 3'd5) begin
                product_reg <= sat_val;
            end
        end
    end

    assign done    = done_reg;
    assign product = product_reg;

endmodule

`default_nettype wire

// File: rtl/lsf_datapath.sv
// Datapath: filter state, scratch registers, saturating ALU and sample conversion.
`default_nettype none

module lsf_datapath import lsf_pkg::*; #(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cmd_t                   cmd,
    input  wire coef_t                  coef,
    input  wire logic [SAMPLE_BITS-1:0] sample_in,
    output stat_t                       stat,
    output logic [SAMPLE_BITS-1:0]      sample_out
);

    localparam int IO_SHIFT = COEF_FRAC_BITS - (SAMPLE_BITS - 1);
    localparam int IO_UP    = (IO_SHIFT > 0) ? IO_SHIFT : 0;
    localparam int IO_DN    = (IO_SHIFT < 0) ? -IO_SHIFT : 0;
    localparam int IO_RND   = (IO_UP > 0) ? IO_UP - 1 : 0;
    localparam logic [63:0] OUT_HALF = (IO_UP > 0) ? (64'd1 << IO_RND) : 64'd0;
    localparam logic [63:0] ONE      = 64'd1 << COEF_FRAC_BITS;
    localparam logic signed [63:0] SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

    // Filter state.
    logic [63:0] x_reg, prev_reg;
    logic [63:0] hp1_reg, hh0_reg, hh1_reg;
    logic [63:0] lp1_reg, lh0_reg, lh1_reg;
    // Scratch.
    logic [63:0] t0_reg, t1_reg, hp1n_reg, hb_reg, lp1n_reg, lb_reg, c9_reg, c10_reg;
    logic [SAMPLE_BITS-1:0] y_reg;

    logic [63:0] opa, opb, alu_res, prod, x_conv, y_conv;
    logic        mul_done;

    function automatic logic [63:0] sat_addsub(input logic [63:0] a, input logic [63:0] b,
                                               input logic sub);
        logic [64:0] s;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] clamp(input logic [63:0] v);
        if ($signed(v) > SMAX) begin
            return SMAX;
        end
        if ($signed(v) < SMIN) begin
            return SMIN;
        end
        return v;
    endfunction

    function automatic logic [63:0] pick(input src_t s);
        logic [63:0] r;
        case (s)
            SRC_ZERO: r = 64'd0;
            SRC_ONE:  r = ONE;
            SRC_A:    r = coef.inv_tan;
            SRC_N:    r = coef.norm;
            SRC_S:    r = coef.inv_tan_sq;
            SRC_P:    r = coef.pole;
            SRC_G:    r = coef.fo_norm;
            SRC_B:    r = coef.bq_fb;
            SRC_K:    r = {1'b0, coef.shelf};
            SRC_X:    r = x_reg;
            SRC_PREV: r = prev_reg;
            SRC_HP1:  r = hp1_reg;
            SRC_HH0:  r = hh0_reg;
            SRC_HH1:  r = hh1_reg;
            SRC_LP1:  r = lp1_reg;
            SRC_LH0:  r = lh0_reg;
            SRC_LH1:  r = lh1_reg;
            SRC_PROD: r = prod;
            SRC_T0:   r = t0_reg;
            SRC_T1:   r = t1_reg;
            SRC_HP1N: r = hp1n_reg;
            SRC_HB:   r = hb_reg;
            SRC_LP1N: r = lp1n_reg;
            SRC_LB:   r = lb_reg;
            SRC_C9:   r = c9_reg;
            SRC_C10:  r = c10_reg;
            default:  r = 64'd0;
        endcase
        return r;
    endfunction

    // The selected registers can change while the selects hold, so both
    // operand muxes are evaluated on every register as well.
    always_comb begin
        opa = pick(cmd.src_a);
        opb = pick(cmd.src_b);
    end

    assign alu_res = sat_addsub(opa, opb, cmd.op == OP_SUB);

    // Sample to Q24.40; extra input bits below the coefficient LSB are floored.
    always_comb begin
        logic signed [63:0] sx;
        sx     = 64'($signed(sample_in));
        x_conv = 64'((sx <<< IO_UP) >>> IO_DN);
    end

    // Q24.40 to sample: round half up, then saturate.
    always_comb begin
        logic [63:0] rnd, dn, c1;
        rnd    = sat_addsub(prod, OUT_HALF, 1'b0);
        dn     = 64'($signed(rnd) >>> IO_UP);
        c1     = clamp(dn);
        y_conv = clamp(c1 << IO_DN);
    end

    lsf_mul #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .op_a    (opa),
        .op_b    (opb),
        .done    (mul_done),
        .product (prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= 64'd0;
            hp1_reg  <= 64'd0;
            hh0_reg  <= 64'd0;
            hh1_reg  <= 64'd0;
            lp1_reg  <= 64'd0;
            lh0_reg  <= 64'd0;
            lh1_reg  <= 64'd0;
        end else if (cmd.clear) begin
            prev_reg <= 64'd0;
            hp1_reg  <= 64'd0;
            hh0_reg  <= 64'd0;
            hh1_reg  <= 64'd0;
            lp1_reg  <= 64'd0;
            lh0_reg  <= 64'd0;
            lh1_reg  <= 64'd0;
        end else if (cmd.out_load) begin
            prev_reg <= x_reg;
            hp1_reg  <= hp1n_reg;
            hh1_reg  <= hh0_reg;
            hh0_reg  <= hb_reg;
            lp1_reg  <= lp1n_reg;
            lh1_reg  <= lh0_reg;
            lh0_reg  <= lb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg <= x_conv;
        end
        if (cmd.out_load) begin
            y_reg <= y_conv[SAMPLE_BITS-1:0];
        end
        if (cmd.alu_we) begin
            case (cmd.dst)
                DST_T0:   t0_reg   <= alu_res;
                DST_T1:   t1_reg   <= alu_res;
                DST_HP1N: hp1n_reg <= alu_res;
                DST_HB:   hb_reg   <= alu_res;
                DST_LP1N: lp1n_reg <= alu_res;
                DST_LB:   lb_reg   <= alu_res;
                DST_C9:   c9_reg   <= alu_res;
                DST_C10:  c10_reg  <= alu_res;
                default:  t0_reg   <= alu_res;
            endcase
        end
    end

    assign stat.mul_done = mul_done;
    assign sample_out    = y_reg;

endmodule

`default_nettype wire

// File: rtl/lsf_ctrl.sv
// Controller: steps the program, drives the datapath and the stream handshakes.
`default_nettype none

module lsf_ctrl import lsf_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    input  wire logic  s_clear,
    output logic       s_ready,
    output logic       m_valid,
    input  wire logic  m_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_MWAIT
    } state_t;

    state_t state_reg;
    pc_t    pc_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;

    instr_t instr;
    logic   accept;
    logic   out_free;

    assign instr    = prog_rom(pc_reg);
    assign accept   = s_valid && s_ready_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd           = '0;
        cmd.capture   = accept && !s_clear;
        cmd.clear     = accept && s_clear;
        cmd.op        = instr.op;
        cmd.src_a     = instr.a;
        cmd.src_b     = instr.b;
        cmd.dst       = instr.dst;
        cmd.alu_we    = (state_reg == ST_RUN) && (instr.kind == K_ALU);
        cmd.mul_start = (state_reg == ST_RUN) && (instr.kind == K_MUL);
        cmd.out_load  = (state_reg == ST_RUN) && (instr.kind == K_OUT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // A new result may replace one that leaves in the same cycle.
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && !s_clear) begin
                        state_reg   <= ST_RUN;
                        pc_reg      <= '0;
                        s_ready_reg <= 1'b0;
                    end else begin
                        s_ready_reg <= 1'b1;
                    end
                end
                ST_RUN: begin
                    case (instr.kind)
                        K_ALU: pc_reg <= pc_reg + 1'b1;
                        K_MUL: state_reg <= ST_MWAIT;
                        K_OUT: begin
                            if (out_free) begin
                                state_reg   <= ST_IDLE;
                                s_ready_reg <= 1'b1;
                            end
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end
                ST_MWAIT: begin
                    if (stat.mul_done) begin
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= ST_RUN;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire
